FILE: hdl/vtv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtv_pkg
// Types, codes and helpers shared by the vertex transform and viewport block.
// ----------------------------------------------------------------------------
package vtv_pkg;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 13;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_IDENT = 2'd1,
      OP_TRANS = 2'd2,
      OP_CONV  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1
   } csr_idx_type;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_TR_MUL = 7'b0000010,
      S_TR_ACC = 7'b0000100,
      S_CV_MUL = 7'b0001000,
      S_CV_SUM = 7'b0010000,
      S_VP_MUL = 7'b0100000,
      S_VP_OUT = 7'b1000000
   } state_type;

   typedef struct packed {
      logic capture;
      logic write_entry;
      logic set_ident;
      logic tr_mul;
      logic tr_acc;
      logic cv_mul;
      logic cv_sum;
      logic vp_mul;
      logic out_load;
   } cmd_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -66'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

FILE: hdl/vtv_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtv_intf
// Request, response and register write channels of the vertex block.
// ----------------------------------------------------------------------------
interface vtv_req_if;
   logic                valid;
   logic                ready;
   vtv_pkg::op_type     op;
   logic [3:0]          entry_index;
   logic signed [31:0]  comp_a;
   logic signed [31:0]  comp_b;
   logic signed [31:0]  comp_c;
   logic signed [31:0]  comp_d;
   logic                last_in_batch;

   modport source (output valid, op, entry_index, comp_a, comp_b, comp_c, comp_d,
                   last_in_batch, input ready);
   modport sink (input valid, op, entry_index, comp_a, comp_b, comp_c, comp_d,
                 last_in_batch, output ready);
endinterface

interface vtv_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  pixel_x;
   logic signed [31:0]  pixel_y;
   logic signed [31:0]  depth;
   logic signed [31:0]  homog_w;
   logic                last;

   modport source (output valid, pixel_x, pixel_y, depth, homog_w, last, input ready);
   modport sink (input valid, pixel_x, pixel_y, depth, homog_w, last, output ready);
endinterface

interface vtv_csr_if;
   logic                               valid;
   logic                               ready;
   logic [vtv_pkg::CSR_IDX_W-1:0]      index;
   logic [vtv_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/vtv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtv_ctrl
// Sequencer: steps translate and convert through the shared multiplier row.
// ----------------------------------------------------------------------------
module vtv_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  vtv_pkg::op_type   req_op,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vtv_pkg::cmd_type  cmd
);

   vtv_pkg::state_type state_ff, state_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               out_valid_ff, out_valid_in;
   logic               accept;
   logic               out_free;

   assign req_ready = (state_ff == vtv_pkg::S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.capture     = accept;
      cmd.write_entry = accept && (req_op == vtv_pkg::OP_LOAD);
      cmd.set_ident   = accept && (req_op == vtv_pkg::OP_IDENT);
      unique case (state_ff)
         vtv_pkg::S_IDLE: begin
            cnt_in = 2'd0;
            if (accept && (req_op == vtv_pkg::OP_TRANS)) begin
               state_in = vtv_pkg::S_TR_MUL;
            end else if (accept && (req_op == vtv_pkg::OP_CONV)) begin
               state_in = vtv_pkg::S_CV_MUL;
            end
         end
         vtv_pkg::S_TR_MUL: begin
            cmd.tr_mul = 1'b1;
            state_in   = vtv_pkg::S_TR_ACC;
         end
         vtv_pkg::S_TR_ACC: begin
            cmd.tr_acc = 1'b1;
            cnt_in     = cnt_ff + 2'd1;
            state_in   = (cnt_ff == 2'd2) ? vtv_pkg::S_IDLE : vtv_pkg::S_TR_MUL;
         end
         vtv_pkg::S_CV_MUL: begin
            cmd.cv_mul = 1'b1;
            cmd.cv_sum = (cnt_ff != 2'd0);
            cnt_in     = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = vtv_pkg::S_CV_SUM;
            end
         end
         vtv_pkg::S_CV_SUM: begin
            cmd.cv_sum = 1'b1;
            state_in   = vtv_pkg::S_VP_MUL;
         end
         vtv_pkg::S_VP_MUL: begin
            cmd.vp_mul = 1'b1;
            state_in   = vtv_pkg::S_VP_OUT;
         end
         vtv_pkg::S_VP_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = vtv_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = vtv_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vtv_pkg::S_IDLE;
         cnt_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

FILE: hdl/vtv_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtv_datapath
// Matrix rows, four-wide multiplier row, row sum, viewport mapping and the
// result register. Rows rotate so the active row always sits in row 0.
// ----------------------------------------------------------------------------
module vtv_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  vtv_pkg::cmd_type                  cmd,
   input  logic [3:0]                        req_entry_index,
   input  logic signed [31:0]                req_comp_a,
   input  logic signed [31:0]                req_comp_b,
   input  logic signed [31:0]                req_comp_c,
   input  logic signed [31:0]                req_comp_d,
   input  logic                              req_last,
   input  logic                              csr_we,
   input  logic [vtv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [vtv_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic signed [31:0]                rsp_pixel_x,
   output logic signed [31:0]                rsp_pixel_y,
   output logic signed [31:0]                rsp_depth,
   output logic signed [31:0]                rsp_homog_w,
   output logic                              rsp_last
);

   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   logic signed [31:0] row_ff [4][4];
   logic signed [31:0] row_in [4][4];
   logic signed [31:0] ident [4][4];
   logic signed [31:0] vec_ff [4];
   logic               last_ff;
   logic signed [63:0] prod_ff [4];
   logic signed [63:0] prod_in [4];
   logic signed [63:0] prod_sh [4];
   logic signed [31:0] tr_new [4];
   logic signed [65:0] row_sum;
   logic signed [31:0] t_ff [4];
   logic signed [45:0] vpx_ff, vpy_ff;
   logic [12:0]        width_ff, height_ff;
   logic signed [47:0] half_w, half_h, full_h, px, py;
   logic signed [31:0] px_ff, py_ff, dz_ff, dw_ff;
   logic               last_out_ff;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            ident[r][c] = (r == c) ? ONE : 32'sd0;
         end
      end
   end

   // multiplier row and floor shift back to the fixed-point scale
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         if (cmd.tr_mul) begin
            prod_in[j] = vec_ff[0] * row_ff[3][j];
         end else begin
            prod_in[j] = row_ff[0][j] * vec_ff[j];
         end
         prod_sh[j] = prod_ff[j] >>> FRAC_BITS;
         tr_new[j]  = vtv_pkg::sat32(66'(row_ff[0][j]) + 66'(prod_sh[j]));
      end
      row_sum = 66'(prod_sh[0]) + 66'(prod_sh[1]) + 66'(prod_sh[2]) + 66'(prod_sh[3]);
   end

   always_comb begin
      row_in = row_ff;
      if (cmd.set_ident) begin
         row_in = ident;
      end else if (cmd.write_entry) begin
         row_in[req_entry_index[3:2]][req_entry_index[1:0]] = req_comp_a;
      end else if (cmd.tr_acc) begin
         row_in[0] = row_ff[1];
         row_in[1] = row_ff[2];
         row_in[2] = tr_new;
      end else if (cmd.cv_mul) begin
         row_in[0] = row_ff[1];
         row_in[1] = row_ff[2];
         row_in[2] = row_ff[3];
         row_in[3] = row_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff    <= ident;
         width_ff  <= 13'd640;
         height_ff <= 13'd480;
      end else begin
         row_ff <= row_in;
         if (csr_we && (csr_index == vtv_pkg::CSR_WIDTH)) begin
            width_ff <= csr_data;
         end
         if (csr_we && (csr_index == vtv_pkg::CSR_HEIGHT)) begin
            height_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         vec_ff[0] <= req_comp_a;
         vec_ff[1] <= req_comp_b;
         vec_ff[2] <= req_comp_c;
         vec_ff[3] <= req_comp_d;
         last_ff   <= req_last;
      end else if (cmd.tr_acc) begin
         vec_ff[0] <= vec_ff[1];
         vec_ff[1] <= vec_ff[2];
      end
      if (cmd.tr_mul || cmd.cv_mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.cv_sum) begin
         t_ff[0] <= t_ff[1];
         t_ff[1] <= t_ff[2];
         t_ff[2] <= t_ff[3];
         t_ff[3] <= vtv_pkg::sat32(row_sum);
      end
      if (cmd.vp_mul) begin
         vpx_ff <= t_ff[0] * $signed({1'b0, height_ff});
         vpy_ff <= t_ff[1] * $signed({1'b0, height_ff});
      end
      if (cmd.out_load) begin
         px_ff       <= vtv_pkg::sat32(66'(px));
         py_ff       <= vtv_pkg::sat32(66'(py));
         dz_ff       <= t_ff[2];
         dw_ff       <= t_ff[3];
         last_out_ff <= last_ff;
      end
   end

   // viewport: halving of x*H and y*H rounds toward minus infinity
   always_comb begin
      half_w = $signed(48'(width_ff) << (FRAC_BITS - 1));
      half_h = $signed(48'(height_ff) << (FRAC_BITS - 1));
      full_h = $signed(48'(height_ff) << FRAC_BITS);
      px     = 48'(vpx_ff >>> 1) + half_w;
      py     = full_h - (48'(vpy_ff >>> 1) + half_h);
   end

   assign rsp_pixel_x = px_ff;
   assign rsp_pixel_y = py_ff;
   assign rsp_depth   = dz_ff;
   assign rsp_homog_w = dw_ff;
   assign rsp_last    = last_out_ff;

endmodule

FILE: hdl/vertex_transform_viewport.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_viewport
// 4x4 fixed-point vertex transform with viewport mapping to pixel space.
// ----------------------------------------------------------------------------
// req_chan takes one request per handshake: load entry, identity, translate
// or convert vertex. Only convert produces a response on rsp_chan.
// csr_chan writes screen width (index 0) and height (index 1); always ready,
// write only while no request is in flight.
// Timing: load and identity complete in the accepting cycle, so the next
// request may follow at once. Translate steps through a multiply and an
// accumulate state for each of the three updated rows. Convert runs four
// multiplier steps, one row per cycle through a row of four 32x32
// multipliers, then a sum step, the viewport multiply and the output load,
// which waits while the output register is full.
// The result sits in an output register; the block goes back to accepting
// requests once it is loaded. If the receiver stalls, a second convert
// waits in its final step until the register frees.
// Reset (synchronous) restores the identity matrix, 640x480 and empties
// the output register.
// ----------------------------------------------------------------------------
module vertex_transform_viewport #(
   parameter int FRAC_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   vtv_req_if.sink   req_chan,
   vtv_rsp_if.source rsp_chan,
   vtv_csr_if.sink   csr_chan
);

   vtv_pkg::cmd_type cmd;

   assign csr_chan.ready = 1'b1;

   vtv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   vtv_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_entry_index (req_chan.entry_index),
      .req_comp_a      (req_chan.comp_a),
      .req_comp_b      (req_chan.comp_b),
      .req_comp_c      (req_chan.comp_c),
      .req_comp_d      (req_chan.comp_d),
      .req_last        (req_chan.last_in_batch),
      .csr_we          (csr_chan.valid),
      .csr_index       (csr_chan.index),
      .csr_data        (csr_chan.data),
      .rsp_pixel_x     (rsp_chan.pixel_x),
      .rsp_pixel_y     (rsp_chan.pixel_y),
      .rsp_depth       (rsp_chan.depth),
      .rsp_homog_w     (rsp_chan.homog_w),
      .rsp_last        (rsp_chan.last)
   );

endmodule

FILE: hdl/vtv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtv_checker
// Port-level checks on the vertex block, bound to the top level.
// ----------------------------------------------------------------------------
module vtv_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input vtv_pkg::op_type    req_op,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_pixel_x,
   input logic signed [31:0] rsp_pixel_y,
   input logic signed [31:0] rsp_depth,
   input logic signed [31:0] rsp_homog_w,
   input logic               rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x)
         && $stable(rsp_pixel_y) && $stable(rsp_depth) && $stable(rsp_homog_w)
         && $stable(rsp_last))
      else $error("stalled response changed");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("reset did not empty the block");

   a_conv_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == vtv_pkg::OP_CONV) |=> !req_ready)
      else $error("convert did not hold off the next request");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op != vtv_pkg::OP_CONV) |=> !$rose(rsp_valid))
      else $error("response without a convert");

endmodule

bind vertex_transform_viewport vtv_checker u_vtv_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_op      (req_chan.op),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_pixel_x (rsp_chan.pixel_x),
   .rsp_pixel_y (rsp_chan.pixel_y),
   .rsp_depth   (rsp_chan.depth),
   .rsp_homog_w (rsp_chan.homog_w),
   .rsp_last    (rsp_chan.last)
);
